FILE: src/pcmc_pkg.sv
// ----------------------------------------------------------------------------
// pcmc_pkg
// Shared types, register indexes, controller commands and AES helpers for
// the payload counter mode cipher.
// ----------------------------------------------------------------------------
package pcmc_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned PosW       = $clog2(BlockBytes);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_LOW     = 3'd0,
    REG_KEY_HIGH    = 3'd1,
    REG_DEV_ADDR    = 3'd2,
    REG_FRAME_COUNT = 3'd3,
    REG_DIRECTION   = 3'd4
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_blk;    // load counter block and round key 0
    logic round_step;  // run one AES round
    logic take_ks;     // latch the state as keystream
    logic emit;        // XOR the pending byte into the output register
  } pcmc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_round;
    logic block_start;
  } pcmc_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

FILE: src/pcmc_ctrl.sv
// ----------------------------------------------------------------------------
// pcmc_ctrl
// Controller: accepts bytes, sequences the ten AES rounds at a block start
// and drives the output register.
// ----------------------------------------------------------------------------
module pcmc_ctrl
  import pcmc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  pcmc_sts_t sts_i,
  output pcmc_cmd_t cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       out_free, accept;

  assign out_free  = !ovalid_q || !out_stall;
  assign in_stall  = (state_q != StIdle);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid_q;

  always_comb begin
    state_d = state_q;
    ovalid_d = ovalid_q && out_stall;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (sts_i.block_start) begin
            cmd_o.load_blk = 1'b1;
            state_d = StRound;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StRound: begin
        cmd_o.round_step = 1'b1;
        if (sts_i.last_round) begin
          cmd_o.take_ks = 1'b1;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          ovalid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !accept) else $error("Byte accepted while busy.");
  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == StIdle && ovalid_q)) else $error("Emit did not complete.");
  a_round_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_blk |=> (state_q == StRound)) else $error("Load not followed by rounds.");
`endif

endmodule

FILE: src/pcmc_dp.sv
// ----------------------------------------------------------------------------
// pcmc_dp
// Datapath: configuration registers, iterative AES-128 round unit with
// on-the-fly key expansion, keystream register, byte position and counter.
// ----------------------------------------------------------------------------
module pcmc_dp
  import pcmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  pcmc_cmd_t           cmd_i,
  output pcmc_sts_t           sts_o,
  output logic [7:0]          out_byte_o,
  output logic                last_out_o
);

  logic [63:0]  key_low_q, key_high_q;
  logic [31:0]  dev_addr_q, frame_count_q;
  logic         direction_q;
  logic [127:0] ks_q;
  logic [PosW-1:0] pos_q;
  logic [7:0]   bcnt_q;
  logic [7:0]   byte_q;
  logic         last_q;
  logic [7:0]   st_q [16];
  logic [7:0]   rk_q [16];
  logic [7:0]   rcon_q;
  logic [3:0]   rnd_q;
  logic [7:0]   obyte_q;
  logic         olast_q;

  logic [7:0] blk [16];
  logic [7:0] key [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] nrk [16];
  logic [7:0] ksb;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key[i]   = key_high_q[63-8*i -: 8];
      key[8+i] = key_low_q[63-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) blk[i] = 8'h00;
    blk[0] = 8'h01;
    blk[5] = {7'd0, direction_q};
    for (int i = 0; i < 4; i++) begin
      blk[6+i]  = dev_addr_q[8*i +: 8];
      blk[10+i] = frame_count_q[8*i +: 8];
    end
    blk[15] = bcnt_q;
  end

  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        t[i+4*c] = SBOX[st_q[i+4*((c+i)%4)]];
    for (int c = 0; c < 4; c++) begin
      logic [7:0] x;
      x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ x ^ xt(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ x ^ xt(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ x ^ xt(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ x ^ xt(t[4*c+3] ^ t[4*c]);
    end
    nrk[0] = rk_q[0] ^ SBOX[rk_q[13]] ^ rcon_q;
    nrk[1] = rk_q[1] ^ SBOX[rk_q[14]];
    nrk[2] = rk_q[2] ^ SBOX[rk_q[15]];
    nrk[3] = rk_q[3] ^ SBOX[rk_q[12]];
    for (int i = 4; i < 16; i++) nrk[i] = rk_q[i] ^ nrk[i-4];
  end

  assign sts_o.last_round  = (rnd_q == 4'd10);
  assign sts_o.block_start = (pos_q == '0);
  assign ksb = ks_q[127-8*pos_q -: 8];
  assign out_byte_o = obyte_q;
  assign last_out_o = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q     <= '0;
      key_high_q    <= '0;
      dev_addr_q    <= '0;
      frame_count_q <= '0;
      direction_q   <= 1'b0;
      ks_q          <= '0;
      pos_q         <= '0;
      bcnt_q        <= 8'h01;
      rnd_q         <= 4'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_KEY_LOW:     key_low_q     <= cfg_data;
          REG_KEY_HIGH:    key_high_q    <= cfg_data;
          REG_DEV_ADDR:    dev_addr_q    <= cfg_data[31:0];
          REG_FRAME_COUNT: frame_count_q <= cfg_data[31:0];
          REG_DIRECTION:   direction_q   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd_i.load_blk) begin
        rnd_q  <= 4'd1;
        bcnt_q <= bcnt_q + 8'd1;
      end else if (cmd_i.round_step) begin
        rnd_q <= rnd_q + 4'd1;
      end
      if (cmd_i.take_ks) begin
        for (int i = 0; i < 16; i++) ks_q[127-8*i -: 8] <= t[i] ^ nrk[i];
      end
      if (cmd_i.emit) begin
        if (last_q) begin
          pos_q  <= '0;
          bcnt_q <= 8'h01;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (cmd_i.load_blk) begin
      for (int i = 0; i < 16; i++) begin
        st_q[i] <= blk[i] ^ key[i];
        rk_q[i] <= key[i];
      end
      rcon_q <= 8'h01;
    end else if (cmd_i.round_step) begin
      for (int i = 0; i < 16; i++) begin
        st_q[i] <= m[i] ^ nrk[i];
        rk_q[i] <= nrk[i];
      end
      rcon_q <= xt(rcon_q);
    end
    if (cmd_i.emit) begin
      obyte_q <= byte_q ^ ksb;
      olast_q <= last_q;
    end
  end

`ifndef SYNTH
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round_step |-> (rnd_q >= 4'd1 && rnd_q <= 4'd10)) else $error("Round out of range.");
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && last_q) |=> (pos_q == '0 && bcnt_q == 8'h01)) else $error("Frame end lost.");
  a_ks_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_ks |=> !cmd_i.round_step) else $error("Rounds overran.");
`endif

endmodule

FILE: src/payload_counter_mode_cipher.sv
// ----------------------------------------------------------------------------
// payload_counter_mode_cipher
// Counter mode cipher for frame payloads, one byte per transaction, with an
// iterative AES-128 keystream generator.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  input   | in_valid / in_stall    | data_byte_i, last_byte_i
//  output  | out_valid / out_stall  | out_byte_o, last_out_o
//  config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A byte that starts a block waits for the ten AES rounds of the shared round
// unit; a byte inside a block does not.
// Reset clears the configuration registers, the keystream and byte position,
// and sets the block counter to one. Output stall holds the result; a new byte
// is taken while a result waits.
module payload_counter_mode_cipher
  import pcmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte_o,
  output logic                last_out_o,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  pcmc_cmd_t cmd;
  pcmc_sts_t sts;

  assign cfg_ready = 1'b1;

  pcmc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd)
  );

  pcmc_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .accept_i(in_valid && !in_stall),
    .data_byte_i, .last_byte_i, .cmd_i(cmd), .sts_o(sts),
    .out_byte_o, .last_out_o
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Payload counter mode cipher testbench
// Drives payload bytes through the cipher under several key, address, frame
// count and direction settings, predicts each output byte with an AES-128
// counter mode model of its own, and checks results in order under random
// idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import pcmc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte_i = '0;
  logic last_byte_i = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte_o;
  logic last_out_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_KEY_LOW;
  logic [CfgDataW-1:0] cfg_data = '0;

  payload_counter_mode_cipher dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_t;

  localparam logic [7:0] SB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic [63:0] key_lo_q, key_hi_q;
  logic [31:0] addr_q, fcnt_q;
  logic        dir_q;
  logic [7:0]  ks_q [16];
  logic [3:0]  pos_q;
  logic [7:0]  ctr_q;

  byte_t expected_bytes [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int bytes_checked = 0;
  int frames_sent = 0;
  int quiet_cycles = 0;

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  task automatic gen_keystream();
    logic [7:0] rk [16];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] rcon, a0, a1, a2, a3, x, k0, k1, k2, k3;
    rcon = 8'h01;
    for (int i = 0; i < 8; i++) begin
      rk[i] = key_hi_q[56-8*i +: 8];
      rk[8+i] = key_lo_q[56-8*i +: 8];
    end
    for (int i = 0; i < 16; i++) s[i] = 8'h00;
    s[0] = 8'h01;
    s[5] = {7'd0, dir_q};
    for (int i = 0; i < 4; i++) begin
      s[6+i] = addr_q[8*i +: 8];
      s[10+i] = fcnt_q[8*i +: 8];
    end
    s[15] = ctr_q;
    for (int i = 0; i < 16; i++) s[i] ^= rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = SB[s[i+4*((c+i)&3)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          t[4*c] = a0 ^ x ^ gmul2(a0 ^ a1);
          t[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
          t[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
          t[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
        end
      end
      k0 = SB[rk[13]]; k1 = SB[rk[14]]; k2 = SB[rk[15]]; k3 = SB[rk[12]];
      rk[0] ^= k0 ^ rcon; rk[1] ^= k1; rk[2] ^= k2; rk[3] ^= k3;
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rcon = gmul2(rcon);
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) ks_q[i] = s[i];
  endtask

  task automatic predict_cipher_byte(input byte_t b);
    byte_t e;
    if (pos_q == 0) begin
      gen_keystream();
      ctr_q++;
    end
    e.data = b.data ^ ks_q[pos_q];
    e.last = b.last;
    expected_bytes.push_back(e);
    if (b.last) begin
      pos_q = 0;
      ctr_q = 8'd1;
    end else begin
      pos_q++;
    end
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_KEY_LOW: key_lo_q = val;
      REG_KEY_HIGH: key_hi_q = val;
      REG_DEV_ADDR: addr_q = val[31:0];
      REG_FRAME_COUNT: fcnt_q = val[31:0];
      REG_DIRECTION: dir_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [63:0] kl, input logic [63:0] kh,
                         input logic [31:0] a, input logic [31:0] f, input logic d);
    write_reg(REG_KEY_LOW, kl);
    write_reg(REG_KEY_HIGH, kh);
    write_reg(REG_DEV_ADDR, {32'd0, a});
    write_reg(REG_FRAME_COUNT, {32'd0, f});
    write_reg(REG_DIRECTION, {63'd0, d});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_byte(input byte_t b);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    data_byte_i <= b.data;
    last_byte_i <= b.last;
    predict_cipher_byte(b);
    do @(posedge clk_i); while (in_stall);
    bytes_sent++;
    if (b.last) frames_sent++;
  endtask

  always @(posedge clk_i) begin
    out_stall <= (stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
  end

  always @(posedge clk_i) begin
    byte_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %h", out_byte_o);
        errors++;
      end else begin
        e = expected_bytes.pop_front();
        bytes_checked++;
        if (out_byte_o !== e.data) begin
          $error("out_byte expected %h actual %h", e.data, out_byte_o);
          errors++;
        end
        if (last_out_o !== e.last) begin
          $error("last_out expected %b actual %b", e.last, last_out_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Directed rows: zero key with default fields, then byte extremes, a short
  // frame, two one-byte frames and a frame crossing a block boundary.
  localparam int NDIR = 24;
  localparam byte_t DIR_ROWS [NDIR] = '{
    '{8'h00, 1'b0}, '{8'hff, 1'b0}, '{8'h55, 1'b0}, '{8'haa, 1'b1},
    '{8'h80, 1'b1},
    '{8'h01, 1'b0}, '{8'h02, 1'b0}, '{8'h04, 1'b0}, '{8'h08, 1'b0},
    '{8'h10, 1'b0}, '{8'h20, 1'b0}, '{8'h40, 1'b0}, '{8'h80, 1'b0},
    '{8'hfe, 1'b0}, '{8'hfd, 1'b0}, '{8'hfb, 1'b0}, '{8'hf7, 1'b0},
    '{8'hef, 1'b0}, '{8'hdf, 1'b0}, '{8'hbf, 1'b0}, '{8'h7f, 1'b0},
    '{8'h00, 1'b0}, '{8'hff, 1'b1}, '{8'h3c, 1'b1}
  };

  task automatic random_frames(input int count, input int max_len);
    byte_t b;
    int len;
    int sent;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(max_len, 1) : $urandom_range(40, 1);
      for (int i = 0; i < len; i++) begin
        b.data = $urandom_range(255, 0);
        b.last = (i == len - 1);
        send_byte(b);
      end
      sent += len;
    end
  endtask

  initial begin
    key_lo_q = '0; key_hi_q = '0; addr_q = '0; fcnt_q = '0; dir_q = 1'b0;
    for (int i = 0; i < 16; i++) ks_q[i] = '0;
    pos_q = '0;
    ctr_q = 8'd1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NDIR; i++) send_byte(DIR_ROWS[i]);
    drain();

    set_all('1, '1, 32'hffffffff, 32'hffffffff, 1'b1);
    random_frames(60, 20);
    drain();

    set_all(64'h0123456789abcdef, 64'hfedcba9876543210, 32'h26011bda, 32'h0, 1'b0);
    // A long frame of 100 bytes runs through several blocks.
    for (int i = 0; i < 100; i++) send_byte('{8'($urandom), i == 99});
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 45 : 20) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 45 : 20) : 0;
      set_all({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom,
              1'($urandom));
      random_frames(110, 60);
      // A frame with the frame count register changed in the middle of a block.
      for (int i = 0; i < 5; i++) send_byte('{8'($urandom), 1'b0});
      drain();
      write_reg(REG_FRAME_COUNT, {32'd0, 32'($urandom)});
      cfg_valid <= 1'b0;
      for (int i = 0; i < 12; i++) send_byte('{8'($urandom), i == 11});
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();

    $display("Checked %0d cipher bytes over %0d frames, including multi-block frames.",
             bytes_checked, frames_sent);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
src/pcmc_pkg.sv
src/pcmc_ctrl.sv
src/pcmc_dp.sv
src/payload_counter_mode_cipher.sv
tb/sv/testbench.sv
